// ----- sv/perspective_vertex_projection_assert.svh -----
// ---------------------------------------------------------------------------
// perspective vertex projection assertion macros
// clocked property checks on clk with and without reset gating
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_VERTEX_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_VERTEX_PROJECTION_ASSERT_SVH

// checked only while out of reset
`define PVP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge including reset
`define PVP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pvp_pkg.sv -----
// ---------------------------------------------------------------------------
// pvp_pkg
// shared constants, register indexes and defaults for the projection block
// ---------------------------------------------------------------------------
package pvp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int TRIG_FRAC       = 14;
    localparam int TRIG_W          = 16;
    localparam int FOCAL_W         = 31;
    localparam int SIZE_W          = 13;
    localparam int REG_INDEX_W     = 4;
    localparam int QUOT_CLAMP_BIT  = 62;

    localparam logic [TRIG_W-1:0]  COS_RESET    = 16'd16384;
    localparam logic [TRIG_W-1:0]  SIN_RESET    = 16'd0;
    localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 31'd65536;
    localparam logic [SIZE_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET = 13'd480;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_EYE_X         = 4'd0,
        REG_EYE_Y         = 4'd1,
        REG_EYE_Z         = 4'd2,
        REG_COS_YAW       = 4'd3,
        REG_SIN_YAW       = 4'd4,
        REG_FOCAL_LENGTH  = 4'd5,
        REG_SCREEN_WIDTH  = 4'd6,
        REG_SCREEN_HEIGHT = 4'd7
    } pvp_reg_t;

endpackage

// ----- sv/pvp_point_if.sv -----
// ---------------------------------------------------------------------------
// pvp_point_if
// world point channel with valid and ready
// ---------------------------------------------------------------------------
interface pvp_point_if #(
    parameter int COORD_WIDTH = pvp_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

// ----- sv/pvp_screen_if.sv -----
// ---------------------------------------------------------------------------
// pvp_screen_if
// projected screen point channel with valid and ready
// ---------------------------------------------------------------------------
interface pvp_screen_if #(
    parameter int COORD_WIDTH = pvp_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;
    logic signed [COORD_WIDTH-1:0] depth_out;
    logic                          zero_depth;

    modport source (output valid, output screen_x, output screen_y, output depth_out,
                    output zero_depth, input ready);
    modport sink (input valid, input screen_x, input screen_y, input depth_out,
                  input zero_depth, output ready);
endinterface

// ----- sv/pvp_cfg_if.sv -----
// ---------------------------------------------------------------------------
// pvp_cfg_if
// register write channel with valid and ready
// ---------------------------------------------------------------------------
interface pvp_cfg_if #(
    parameter int DATA_W = pvp_pkg::COORD_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [pvp_pkg::REG_INDEX_W-1:0] index;
    logic [DATA_W-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/pvp_div_pipe.sv -----
// ---------------------------------------------------------------------------
// pvp_div_pipe
// two lane restoring divider, one quotient bit per stage, shared divisor
// ---------------------------------------------------------------------------
module pvp_div_pipe #(
    parameter int NUM_W  = 67,
    parameter int DEN_W  = 36,
    parameter int QUO_W  = 33,
    parameter int SIDE_W = 35
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num_x,
    input  logic [NUM_W-1:0]  num_y,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo_x,
    output logic [QUO_W-1:0]  quo_y,
    output logic              ovf_x,
    output logic              ovf_y,
    output logic [SIDE_W-1:0] side_out
);
    localparam int HW   = NUM_W - QUO_W;
    localparam int CMPW = (HW > DEN_W) ? HW : DEN_W;

    logic [DEN_W-1:0]  rem_reg  [0:1][0:QUO_W];
    logic [DEN_W-1:0]  rem_next [0:1][0:QUO_W];
    logic [QUO_W-1:0]  lo_reg   [0:1][0:QUO_W];
    logic [QUO_W-1:0]  lo_next  [0:1][0:QUO_W];
    logic [QUO_W-1:0]  q_reg    [0:1][0:QUO_W];
    logic [QUO_W-1:0]  q_next   [0:1][0:QUO_W];
    logic              ovf_reg  [0:1][0:QUO_W];
    logic              ovf_next [0:1][0:QUO_W];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W];
    logic [DEN_W-1:0]  den_next [0:QUO_W];
    logic [SIDE_W-1:0] side_reg [0:QUO_W];
    logic [SIDE_W-1:0] side_next[0:QUO_W];
    logic              valid_reg  [0:QUO_W];
    logic              valid_next [0:QUO_W];

    always_comb
    begin
        logic [NUM_W-1:0] num;
        logic [CMPW-1:0]  hi;
        logic [DEN_W:0]   trial;
        den_next[0]   = den;
        side_next[0]  = side_in;
        valid_next[0] = in_valid;
        for (int s = 1; s <= QUO_W; s++)
        begin
            den_next[s]   = den_reg[s-1];
            side_next[s]  = side_reg[s-1];
            valid_next[s] = valid_reg[s-1];
        end
        for (int l = 0; l < 2; l++)
        begin
            num = (l == 0) ? num_x : num_y;
            hi  = CMPW'(num[NUM_W-1:QUO_W]);
            ovf_next[l][0] = (hi >= CMPW'(den));
            rem_next[l][0] = DEN_W'(hi);
            lo_next[l][0]  = num[QUO_W-1:0];
            q_next[l][0]   = '0;
            for (int s = 1; s <= QUO_W; s++)
            begin
                trial = {rem_reg[l][s-1], lo_reg[l][s-1][QUO_W-1]};
                if (trial >= {1'b0, den_reg[s-1]})
                begin
                    rem_next[l][s] = DEN_W'(trial - {1'b0, den_reg[s-1]});
                    q_next[l][s]   = {q_reg[l][s-1][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l][s] = trial[DEN_W-1:0];
                    q_next[l][s]   = {q_reg[l][s-1][QUO_W-2:0], 1'b0};
                end
                lo_next[l][s]  = lo_reg[l][s-1] << 1;
                ovf_next[l][s] = ovf_reg[l][s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QUO_W; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s <= QUO_W; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= QUO_W; s++)
            begin
                den_reg[s]  <= den_next[s];
                side_reg[s] <= side_next[s];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l][s] <= rem_next[l][s];
                    lo_reg[l][s]  <= lo_next[l][s];
                    q_reg[l][s]   <= q_next[l][s];
                    ovf_reg[l][s] <= ovf_next[l][s];
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo_x     = q_reg[0][QUO_W];
    assign quo_y     = q_reg[1][QUO_W];
    assign ovf_x     = ovf_reg[0][QUO_W];
    assign ovf_y     = ovf_reg[1][QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

// ----- sv/perspective_vertex_projection.sv -----
// ---------------------------------------------------------------------------
// perspective_vertex_projection
// eye offset, yaw rotation, focal scale over depth and screen centering
// ---------------------------------------------------------------------------
// channel  direction  payload
// point    in         point_x point_y point_z
// screen   out        screen_x screen_y depth_out zero_depth
// cfg      in         index data
//
// one point per cycle sustained while the screen channel is not stalled;
// the divider resolves one quotient bit per stage
// reset clears all valid bits and loads register defaults
// a stalled result freezes the whole pipeline; nothing is dropped or repeated
// ---------------------------------------------------------------------------
module perspective_vertex_projection #(
    parameter int COORD_WIDTH = pvp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pvp_pkg::FRAC_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    pvp_point_if.sink    point,
    pvp_screen_if.source screen,
    pvp_cfg_if.sink      cfg
);
    import pvp_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = DW + TRIG_W;
    localparam int SW   = PW + 1;
    localparam int RW   = SW - TRIG_FRAC;
    localparam int NW   = RW + FOCAL_W;
    localparam int QW   = COORD_WIDTH + 1;
    localparam int OW   = (QW > QUOT_CLAMP_BIT) ? QW + 1 : QUOT_CLAMP_BIT + 1;
    localparam int TW   = OW + 2;
    localparam int SIDE = COORD_WIDTH + 3;

    localparam logic signed [SW-1:0] HALF   = SW'(1 << (TRIG_FRAC - 1));
    localparam logic [OW-1:0]        QCLAMP = OW'(1) << QUOT_CLAMP_BIT;
    localparam logic signed [TW-1:0] SAT_HI = TW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);

    // configuration
    logic signed [COORD_WIDTH-1:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic signed [TRIG_W-1:0]      cos_reg, sin_reg;
    logic [FOCAL_W-1:0]            focal_reg;
    logic [SIZE_W-1:0]             width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg  <= '0;
            eye_y_reg  <= '0;
            eye_z_reg  <= '0;
            cos_reg    <= COS_RESET;
            sin_reg    <= SIN_RESET;
            focal_reg  <= FOCAL_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (pvp_reg_t'(cfg.index))
                REG_EYE_X:         eye_x_reg  <= cfg.data[COORD_WIDTH-1:0];
                REG_EYE_Y:         eye_y_reg  <= cfg.data[COORD_WIDTH-1:0];
                REG_EYE_Z:         eye_z_reg  <= cfg.data[COORD_WIDTH-1:0];
                REG_COS_YAW:       cos_reg    <= cfg.data[TRIG_W-1:0];
                REG_SIN_YAW:       sin_reg    <= cfg.data[TRIG_W-1:0];
                REG_FOCAL_LENGTH:  focal_reg  <= cfg.data[FOCAL_W-1:0];
                REG_SCREEN_WIDTH:  width_reg  <= cfg.data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // pipeline control
    logic f_valid_reg;
    logic en;
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic div_valid;

    assign en          = !f_valid_reg || screen.ready;
    assign point.ready = en;

    // stage a: eye offset
    logic signed [DW-1:0]          a_dx_reg, a_dy_reg, a_dz_reg;
    logic signed [COORD_WIDTH-1:0] a_pz_reg;
    // stage b: rotation products
    logic signed [PW-1:0]          b_xc_reg, b_zs_reg, b_zc_reg, b_xs_reg;
    logic signed [DW-1:0]          b_dy_reg;
    logic signed [COORD_WIDTH-1:0] b_pz_reg;
    // stage c: rounded rotation
    logic signed [RW-1:0]          c_rx_reg, c_ry_reg, c_rz_reg;
    logic signed [COORD_WIDTH-1:0] c_pz_reg;
    // stage d: magnitudes and signs
    logic [RW-1:0]                 d_mx_reg, d_my_reg, d_mz_reg;
    logic [SIDE-1:0]               d_side_reg;
    // stage e: numerators
    logic [NW-1:0]                 e_nx_reg, e_ny_reg;
    logic [RW-1:0]                 e_mz_reg;
    logic [SIDE-1:0]               e_side_reg;
    // stage f: output
    logic signed [COORD_WIDTH-1:0] f_sx_reg, f_sy_reg, f_pz_reg;
    logic                          f_zero_reg;

    logic signed [SW-1:0] c_sum_x, c_sum_z;
    assign c_sum_x = SW'(b_xc_reg) + SW'(b_zs_reg) + HALF;
    assign c_sum_z = SW'(b_zc_reg) - SW'(b_xs_reg) + HALF;

    logic [QW-1:0]   q_x, q_y;
    logic            ovf_x, ovf_y;
    logic [SIDE-1:0] div_side;

    pvp_div_pipe #(
        .NUM_W  (NW),
        .DEN_W  (RW),
        .QUO_W  (QW),
        .SIDE_W (SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num_x     (e_nx_reg),
        .num_y     (e_ny_reg),
        .den       (e_mz_reg),
        .side_in   (e_side_reg),
        .out_valid (div_valid),
        .quo_x     (q_x),
        .quo_y     (q_y),
        .ovf_x     (ovf_x),
        .ovf_y     (ovf_y),
        .side_out  (div_side)
    );

    // final sign, centering and saturation
    logic                          f_sign_x, f_sign_y, f_zero;
    logic signed [COORD_WIDTH-1:0] f_pz;
    logic [OW-1:0]                 f_qx, f_qy;
    logic signed [TW-1:0]          f_tx, f_ty;
    logic signed [COORD_WIDTH-1:0] f_sx_next, f_sy_next;

    always_comb
    begin
        {f_sign_x, f_sign_y, f_zero, f_pz} = div_side;
        f_qx = (ovf_x || OW'(q_x) > QCLAMP) ? QCLAMP : OW'(q_x);
        f_qy = (ovf_y || OW'(q_y) > QCLAMP) ? QCLAMP : OW'(q_y);
        f_tx = (f_sign_x ? -signed'(TW'(f_qx)) : signed'(TW'(f_qx)))
             + signed'(TW'(width_reg) << (FRAC_BITS - 1));
        f_ty = (f_sign_y ? -signed'(TW'(f_qy)) : signed'(TW'(f_qy)))
             + signed'(TW'(height_reg) << (FRAC_BITS - 1));
        if (f_zero)
            f_sx_next = '0;
        else if (f_tx > SAT_HI)
            f_sx_next = COORD_WIDTH'(SAT_HI);
        else if (f_tx < SAT_LO)
            f_sx_next = COORD_WIDTH'(SAT_LO);
        else
            f_sx_next = COORD_WIDTH'(f_tx);
        if (f_zero)
            f_sy_next = '0;
        else if (f_ty > SAT_HI)
            f_sy_next = COORD_WIDTH'(SAT_HI);
        else if (f_ty < SAT_LO)
            f_sy_next = COORD_WIDTH'(SAT_LO);
        else
            f_sy_next = COORD_WIDTH'(f_ty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= point.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg <= DW'(point.point_x) - DW'(eye_x_reg);
            a_dy_reg <= DW'(point.point_y) - DW'(eye_y_reg);
            a_dz_reg <= DW'(point.point_z) - DW'(eye_z_reg);
            a_pz_reg <= point.point_z;

            b_xc_reg <= PW'(a_dx_reg) * PW'(cos_reg);
            b_zs_reg <= PW'(a_dz_reg) * PW'(sin_reg);
            b_zc_reg <= PW'(a_dz_reg) * PW'(cos_reg);
            b_xs_reg <= PW'(a_dx_reg) * PW'(sin_reg);
            b_dy_reg <= a_dy_reg;
            b_pz_reg <= a_pz_reg;

            c_rx_reg <= RW'(c_sum_x >>> TRIG_FRAC);
            c_rz_reg <= RW'(c_sum_z >>> TRIG_FRAC);
            c_ry_reg <= RW'(b_dy_reg);
            c_pz_reg <= b_pz_reg;

            d_mx_reg   <= c_rx_reg[RW-1] ? $unsigned(-c_rx_reg) : $unsigned(c_rx_reg);
            d_my_reg   <= c_ry_reg[RW-1] ? $unsigned(-c_ry_reg) : $unsigned(c_ry_reg);
            d_mz_reg   <= c_rz_reg[RW-1] ? $unsigned(-c_rz_reg) : $unsigned(c_rz_reg);
            d_side_reg <= {c_rx_reg[RW-1] ^ c_rz_reg[RW-1], c_ry_reg[RW-1] ^ c_rz_reg[RW-1],
                           c_rz_reg == '0, c_pz_reg};

            e_nx_reg   <= NW'(d_mx_reg) * NW'(focal_reg);
            e_ny_reg   <= NW'(d_my_reg) * NW'(focal_reg);
            e_mz_reg   <= d_mz_reg;
            e_side_reg <= d_side_reg;

            f_sx_reg   <= f_sx_next;
            f_sy_reg   <= f_sy_next;
            f_pz_reg   <= f_pz;
            f_zero_reg <= f_zero;
        end
    end

    assign screen.valid      = f_valid_reg;
    assign screen.screen_x   = f_sx_reg;
    assign screen.screen_y   = f_sy_reg;
    assign screen.depth_out  = f_pz_reg;
    assign screen.zero_depth = f_zero_reg;

endmodule

// ----- sv/pvp_checker.sv -----
// ---------------------------------------------------------------------------
// pvp_checker
// port level checks on the projection block, bound to the top level
// ---------------------------------------------------------------------------
`include "perspective_vertex_projection_assert.svh"

module pvp_checker #(
    parameter int COORD_WIDTH = pvp_pkg::COORD_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_WIDTH-1:0] screen_x,
    input logic signed [COORD_WIDTH-1:0] screen_y,
    input logic                          zero_depth
);
    logic [7:0] outstanding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else
            outstanding_reg <= outstanding_reg + 8'(in_valid && in_ready)
                             - 8'(out_valid && out_ready);
    end

    `PVP_ASSERT_RST(reset_quiet, !rst_n |-> !out_valid, "result valid during reset")
    `PVP_ASSERT(out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `PVP_ASSERT(stall_blocks_input, out_valid && !out_ready |-> !in_ready, "input taken in stall")
    `PVP_ASSERT(no_phantom, out_valid |-> outstanding_reg != 8'd0, "result without a point")
    `PVP_ASSERT(zero_clears, out_valid && zero_depth |-> screen_x == 0 && screen_y == 0, "zero depth")

endmodule

bind perspective_vertex_projection pvp_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_pvp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (point.valid),
    .in_ready   (point.ready),
    .out_valid  (screen.valid),
    .out_ready  (screen.ready),
    .screen_x   (screen.screen_x),
    .screen_y   (screen.screen_y),
    .zero_depth (screen.zero_depth)
);

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// projection testbench: random and directed world points are pushed through
// the block under several eye, yaw, focal and screen settings; every
// projected point is checked against an in-bench predictor
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pvp_pkg::*;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } point_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] dz;
        logic               zero;
    } proj_t;

    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    pvp_point_if  point ();
    pvp_screen_if screen ();
    pvp_cfg_if    cfg ();

    perspective_vertex_projection uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .screen (screen),
        .cfg    (cfg)
    );

    // shadow registers
    logic signed [31:0] eye_x_r, eye_y_r, eye_z_r;
    logic signed [15:0] cos_r, sin_r;
    logic [30:0]        focal_r;
    logic [12:0]        width_r, height_r;

    point_t pending_points[$];
    proj_t  expected_proj[$];
    int     errors;
    longint cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic signed [63:0] floor_q14(logic signed [63:0] v);
        return v >>> TRIG_FRAC;
    endfunction

    function automatic logic signed [31:0] scale_axis(logic signed [63:0] r,
                                                      logic signed [63:0] rz,
                                                      logic [12:0] size);
        logic [127:0]       num;
        logic [127:0]       quo;
        logic [63:0]        mr, mz;
        logic signed [65:0] sum;
        mr = r[63] ? -r : r;
        mz = rz[63] ? -rz : rz;
        num = {64'd0, mr} * {97'd0, focal_r};
        quo = num / {64'd0, mz};
        if (quo > (128'd1 << 62))
            quo = 128'd1 << 62;
        if (r[63] != rz[63])
            sum = -$signed({2'b00, quo[63:0]});
        else
            sum = $signed({2'b00, quo[63:0]});
        sum = sum + $signed({36'd0, size, 17'd0} >> 2);
        if (sum > 66'sd2147483647)
            return 32'h7fffffff;
        if (sum < -66'sd2147483648)
            return 32'h80000000;
        return sum[31:0];
    endfunction

    function automatic proj_t project_point(point_t p);
        proj_t              e;
        logic signed [63:0] dx, dy, dz, rx, rz;
        dx = 64'(p.px) - 64'(eye_x_r);
        dy = 64'(p.py) - 64'(eye_y_r);
        dz = 64'(p.pz) - 64'(eye_z_r);
        rx = floor_q14(dx * 64'(cos_r) + dz * 64'(sin_r) + 64'sd8192);
        rz = floor_q14(dz * 64'(cos_r) - dx * 64'(sin_r) + 64'sd8192);
        e.dz = p.pz;
        e.zero = (rz == 0);
        e.sx = 0;
        e.sy = 0;
        if (!e.zero)
        begin
            e.sx = scale_axis(rx, rz, width_r);
            e.sy = scale_axis(dy, rz, height_r);
        end
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s got %h want %h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.valid <= 1'b0;
            point.point_x <= '0;
            point.point_y <= '0;
            point.point_z <= '0;
        end
        else if (!point.valid || point.ready)
        begin
            if (point.valid)
                void'(pending_points.pop_front());
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                point_t nx;
                nx = pending_points[0];
                point.valid <= 1'b1;
                point.point_x <= nx.px;
                point.point_y <= nx.py;
                point.point_z <= nx.pz;
            end
            else
                point.valid <= 1'b0;
        end
    end

    // prediction on each accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && point.valid && point.ready)
            expected_proj.push_back(project_point({point.point_x, point.point_y,
                                                   point.point_z}));
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            screen.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            screen.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            screen.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && screen.valid && screen.ready)
        begin
            if (expected_proj.size() == 0)
            begin
                $display("unexpected transfer on screen channel");
                errors++;
            end
            else
            begin
                proj_t e;
                e = expected_proj.pop_front();
                if (screen.screen_x !== e.sx)
                    report_mismatch("screen_x", screen.screen_x, e.sx);
                if (screen.screen_y !== e.sy)
                    report_mismatch("screen_y", screen.screen_y, e.sy);
                if (screen.depth_out !== e.dz)
                    report_mismatch("depth_out", screen.depth_out, e.dz);
                if (screen.zero_depth !== e.zero)
                    report_mismatch("zero_depth", {31'd0, screen.zero_depth},
                                    {31'd0, e.zero});
            end
        end
    end

    task automatic write_reg(pvp_reg_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_EYE_X:         eye_x_r = value;
            REG_EYE_Y:         eye_y_r = value;
            REG_EYE_Z:         eye_z_r = value;
            REG_COS_YAW:       cos_r = value[15:0];
            REG_SIN_YAW:       sin_r = value[15:0];
            REG_FOCAL_LENGTH:  focal_r = value[30:0];
            REG_SCREEN_WIDTH:  width_r = value[12:0];
            REG_SCREEN_HEIGHT: height_r = value[12:0];
            default:           ;
        endcase
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || point.valid || expected_proj.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(2000000)) - 1000000;
            2:       return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            default: return $signed($urandom_range(200)) * 65536 - 100 * 65536;
        endcase
    endfunction

    task automatic push_random(int n);
        point_t p;
        repeat (n)
        begin
            p.px = rand_coord();
            p.py = rand_coord();
            p.pz = rand_coord();
            if ($urandom_range(19) == 0)
                p.pz = eye_z_r;
            pending_points.push_back(p);
        end
    endtask

    task automatic random_settings();
        logic signed [15:0] c, s;
        write_reg(REG_EYE_X, rand_coord());
        write_reg(REG_EYE_Y, rand_coord());
        write_reg(REG_EYE_Z, rand_coord());
        c = 16'($signed($urandom_range(32768)) - 16384);
        s = 16'($signed($urandom_range(32768)) - 16384);
        if ($urandom_range(3) == 0)
            c = 16'($urandom);
        write_reg(REG_COS_YAW, {16'd0, c});
        write_reg(REG_SIN_YAW, {16'd0, s});
        write_reg(REG_FOCAL_LENGTH, $urandom_range(1) ? $urandom_range(1 << 22) : $urandom);
        write_reg(REG_SCREEN_WIDTH, $urandom_range(8191));
        write_reg(REG_SCREEN_HEIGHT, $urandom_range(4096, 1));
    endtask

    initial
    begin
        point_t p;
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 34;
        recv_idle_pct = 78;
        eye_x_r = 0;
        eye_y_r = 0;
        eye_z_r = 0;
        cos_r = COS_RESET;
        sin_r = SIN_RESET;
        focal_r = FOCAL_RESET;
        width_r = WIDTH_RESET;
        height_r = HEIGHT_RESET;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points at reset settings
        pending_points.push_back('{32'sd0, 32'sd0, 32'sd0});
        pending_points.push_back('{32'sd65536, 32'sd65536, 32'sd65536});
        pending_points.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        pending_points.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
        pending_points.push_back('{32'h7fffffff, 32'h80000000, 32'sd1});
        pending_points.push_back('{32'h80000000, 32'h7fffffff, -32'sd1});
        pending_points.push_back('{32'hffffffff, 32'h00000001, 32'sd2});
        drain();

        // extreme settings
        write_reg(REG_EYE_X, 32'h80000000);
        write_reg(REG_EYE_Y, 32'h7fffffff);
        write_reg(REG_EYE_Z, 32'h80000000);
        write_reg(REG_COS_YAW, 32'hffffc000);
        write_reg(REG_SIN_YAW, 32'h00004000);
        write_reg(REG_FOCAL_LENGTH, 32'h7fffffff);
        write_reg(REG_SCREEN_WIDTH, 32'd0);
        write_reg(REG_SCREEN_HEIGHT, 32'd8191);
        write_reg(pvp_reg_t'(4'd9), 32'h12345678);
        pending_points.push_back('{32'h7fffffff, 32'h80000000, 32'h7fffffff});
        pending_points.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000});
        pending_points.push_back('{32'sd0, 32'sd0, 32'h80000000});
        pending_points.push_back('{32'h80000000, 32'sd0, 32'h80000000});
        push_random(6);
        drain();

        write_reg(REG_FOCAL_LENGTH, 32'd0);
        write_reg(REG_COS_YAW, 32'h00007fff);
        write_reg(REG_SIN_YAW, 32'h00008000);
        write_reg(REG_SCREEN_WIDTH, 32'd4096);
        write_reg(REG_SCREEN_HEIGHT, 32'd1);
        push_random(6);
        drain();

        // random phases
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 34;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_settings();
            if (ph == 7)
                hold_cycles <= 300;
            push_random(125);
            drain();
        end

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/pvp_pkg.sv
sv/pvp_point_if.sv
sv/pvp_screen_if.sv
sv/pvp_cfg_if.sv
sv/pvp_div_pipe.sv
sv/perspective_vertex_projection.sv
sv/pvp_checker.sv
dv/tb_top.sv
